FILE: hdl/sals_pkg.sv
// ----------------------------------------------------------------------------
// Shared ADC level sampler package
// Widths, reset values, codes and the status flag group shared by the
// sampler's modules.
// ----------------------------------------------------------------------------
package sals_pkg;

	// Default width of a converter reading.
	localparam int SAMPLE_BITS_DEF = 12;

	// Fixed field widths.
	localparam int CFG_W     = 16;
	localparam int PERIOD_W  = 16;
	localparam int TIMEOUT_W = 8;
	localparam int LEVEL_W   = 7;
	localparam int OUT_W     = 16;

	// Register reset values.
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd100;
	localparam logic [CFG_W-1:0]     FULL_RESET    = 16'd2200;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd10;

	// Top of the percent scale.
	localparam logic [LEVEL_W-1:0] PCT_FULL = 7'd100;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_DONE  = 2'd1,
		ACT_ERROR = 2'd2
	} action_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PERIOD  = 2'd0,
		REG_EMPTY   = 2'd1,
		REG_FULL    = 2'd2,
		REG_TIMEOUT = 2'd3
	} reg_index_t;

	// Per-beat status flags of a result.
	typedef struct packed {
		logic timed_out;
		logic stop_conv;
		logic start_conv;
		logic held;
		logic updated;
	} flags_t;

endpackage

FILE: hdl/sals_div.sv
// ----------------------------------------------------------------------------
// Bit-serial percent divider
// Computes floor(num * 100 / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sals_div #(
	parameter int SAMPLE_BITS = sals_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [SAMPLE_BITS-1:0]       num,
	input  logic [SAMPLE_BITS-1:0]       den,
	output logic                         done,
	output logic [sals_pkg::LEVEL_W-1:0] quo
);

	localparam int NW = SAMPLE_BITS + 7;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]                  n_q;
	logic [SAMPLE_BITS-1:0]         rem_q;
	logic [SAMPLE_BITS-1:0]         den_q;
	logic [CW-1:0]                  cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [sals_pkg::LEVEL_W-1:0]   quo_q;
	logic [NW-1:0]                  prod;
	logic [SAMPLE_BITS:0]           rem_sh;
	logic [SAMPLE_BITS:0]           rem_nx;
	logic                           fits;

	// num * 100 as num * (64 + 32 + 4).
	assign prod = {1'b0, num, 6'b0} + {2'b0, num, 5'b0} + {5'b0, num, 2'b0};

	always_comb begin
		rem_sh = {rem_q, n_q[NW-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= CW'(NW);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q   <= prod;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			n_q   <= {n_q[NW-2:0], 1'b0};
			rem_q <= rem_nx[SAMPLE_BITS-1:0];
			quo_q <= {quo_q[sals_pkg::LEVEL_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/sals_ctrl.sv
// ----------------------------------------------------------------------------
// Sampler control
// Holds the sampler state, applies one item at a time and sequences the
// serial percent division when a published reading lies strictly between the calibration points.
// ----------------------------------------------------------------------------
module sals_ctrl #(
	parameter int SAMPLE_BITS = sals_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [SAMPLE_BITS-1:0]         sample,
	input  logic                           busy,
	input  logic                           lost,
	input  logic                           setup,
	input  logic                           started,
	input  logic [sals_pkg::PERIOD_W-1:0]  sample_period,
	input  logic [SAMPLE_BITS-1:0]         empty_level,
	input  logic [SAMPLE_BITS-1:0]         full_level,
	input  logic [sals_pkg::TIMEOUT_W-1:0] timeout_ticks,
	output logic                           res_valid,
	input  logic                           res_take,
	output logic [sals_pkg::LEVEL_W-1:0]   res_level,
	output sals_pkg::flags_t               res_flags
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	logic                           waiting_q;
	logic [sals_pkg::PERIOD_W-1:0]  period_cnt_q;
	logic [sals_pkg::TIMEOUT_W-1:0] wait_cnt_q;
	logic                           ready_flag_q;
	logic                           error_flag_q;
	logic [SAMPLE_BITS-1:0]         captured_q;
	logic [sals_pkg::LEVEL_W-1:0]   level_q;
	logic                           holding_q;
	sals_pkg::flags_t               flags_q;

	logic                           accept;
	logic                           waiting_nx;
	logic [sals_pkg::PERIOD_W-1:0]  period_cnt_nx;
	logic [sals_pkg::TIMEOUT_W-1:0] wait_cnt_nx;
	logic [sals_pkg::TIMEOUT_W-1:0] wait_inc;
	logic                           ready_flag_nx;
	logic                           error_flag_nx;
	logic [SAMPLE_BITS-1:0]         captured_nx;
	logic                           holding_nx;
	sals_pkg::flags_t               flags_nx;
	logic                           publish;

	logic                           need_div;
	logic [sals_pkg::LEVEL_W-1:0]   clamp_level;
	logic [SAMPLE_BITS-1:0]         div_num;
	logic [SAMPLE_BITS-1:0]         div_den;
	logic                           div_go;
	logic                           div_done;
	logic [sals_pkg::LEVEL_W-1:0]   div_quo;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wait_inc = wait_cnt_q + sals_pkg::TIMEOUT_W'(1);

	// Next state for one item.
	always_comb begin
		waiting_nx    = waiting_q;
		period_cnt_nx = period_cnt_q;
		wait_cnt_nx   = wait_cnt_q;
		ready_flag_nx = ready_flag_q;
		error_flag_nx = error_flag_q;
		captured_nx   = captured_q;
		holding_nx    = holding_q;
		flags_nx      = '0;
		publish       = 1'b0;
		case (sals_pkg::action_t'(action))
			sals_pkg::ACT_DONE: begin
				captured_nx   = sample;
				ready_flag_nx = 1'b1;
			end
			sals_pkg::ACT_ERROR: begin
				error_flag_nx = 1'b1;
			end
			sals_pkg::ACT_TICK: begin
				if (!waiting_q) begin
					if (period_cnt_q < sample_period) begin
						period_cnt_nx = period_cnt_q + sals_pkg::PERIOD_W'(1);
					end else begin
						period_cnt_nx = '0;
						if (!busy && setup) begin
							ready_flag_nx       = 1'b0;
							error_flag_nx       = 1'b0;
							wait_cnt_nx         = '0;
							flags_nx.start_conv = 1'b1;
							waiting_nx          = started;
							holding_nx          = started;
						end
					end
				end else if (lost) begin
					ready_flag_nx = 1'b0;
					error_flag_nx = 1'b0;
					waiting_nx    = 1'b0;
					holding_nx    = 1'b0;
				end else if (ready_flag_q) begin
					ready_flag_nx      = 1'b0;
					flags_nx.stop_conv = 1'b1;
					flags_nx.updated   = 1'b1;
					holding_nx         = 1'b0;
					waiting_nx         = 1'b0;
					publish            = 1'b1;
				end else if (error_flag_q) begin
					error_flag_nx      = 1'b0;
					flags_nx.stop_conv = 1'b1;
					holding_nx         = 1'b0;
					waiting_nx         = 1'b0;
				end else begin
					wait_cnt_nx = wait_inc;
					if (wait_inc >= timeout_ticks) begin
						flags_nx.stop_conv = 1'b1;
						flags_nx.timed_out = 1'b1;
						holding_nx         = 1'b0;
						waiting_nx         = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		flags_nx.held = holding_nx;
	end

	// Clamp the captured reading against the calibration; only a reading
	// strictly between the two points needs the divider.
	always_comb begin
		need_div    = 1'b0;
		clamp_level = '0;
		div_num     = '0;
		div_den     = '0;
		if (full_level > empty_level) begin
			if (captured_q <= empty_level) begin
				clamp_level = '0;
			end else if (captured_q >= full_level) begin
				clamp_level = sals_pkg::PCT_FULL;
			end else begin
				need_div = 1'b1;
				div_num  = captured_q - empty_level;
				div_den  = full_level - empty_level;
			end
		end else if (full_level < empty_level) begin
			if (captured_q >= empty_level) begin
				clamp_level = '0;
			end else if (captured_q <= full_level) begin
				clamp_level = sals_pkg::PCT_FULL;
			end else begin
				need_div = 1'b1;
				div_num  = empty_level - captured_q;
				div_den  = empty_level - full_level;
			end
		end
	end

	assign div_go = accept && publish && need_div;

	sals_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			waiting_q    <= 1'b0;
			period_cnt_q <= sals_pkg::PERIOD_RESET;
			wait_cnt_q   <= '0;
			ready_flag_q <= 1'b0;
			error_flag_q <= 1'b0;
			captured_q   <= '0;
			level_q      <= '0;
			holding_q    <= 1'b0;
			flags_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						waiting_q    <= waiting_nx;
						period_cnt_q <= period_cnt_nx;
						wait_cnt_q   <= wait_cnt_nx;
						ready_flag_q <= ready_flag_nx;
						error_flag_q <= error_flag_nx;
						captured_q   <= captured_nx;
						holding_q    <= holding_nx;
						flags_q      <= flags_nx;
						if (div_go) begin
							state_q <= ST_DIVIDE;
						end else begin
							if (publish) begin
								level_q <= clamp_level;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						level_q <= div_quo;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = (state_q == ST_EMIT);
	assign res_level = level_q;
	assign res_flags = flags_q;

endmodule

FILE: hdl/shared_adc_level_sampler.sv
// ----------------------------------------------------------------------------
// Shared ADC level sampler
// Periodic tank level sampler that borrows a shared converter.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. Tick beats count out the
// sample period, claim the converter, wait for a completion or error beat and
// end the wait by publish, error, ownership loss or timeout; completion and
// error beats only latch. One beat is worked on at a time: an accepted beat is
// registered in the control state and then moves to the output register, and a
// tick that publishes a reading strictly between the calibration points first
// waits in the divide state for the bit-serial percent divider, which retires
// one quotient bit per cycle. The output register lets a new beat be accepted
// while the previous result waits.
// Configuration registers may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module shared_adc_level_sampler #(
	parameter int SAMPLE_BITS = sals_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [sals_pkg::CFG_W-1:0]      cfg_data,

	// Input beats.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// From bit 0: adc_sample, adc_busy_elsewhere, owner_lost, setup_ok,
	// start_ok, zero fill.
	input  logic [((SAMPLE_BITS+4+7)/8)*8-1:0] s_tdata,
	// action (0 tick, 1 conversion complete, 2 conversion error).
	input  logic [1:0]                      s_tuser,

	// Result beats.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// From bit 0: level_percent[6:0], level_updated, adc_held,
	// start_conversion, stop_conversion, timed_out, zero fill.
	output logic [sals_pkg::OUT_W-1:0]      m_tdata
);

	localparam int OUT_PAD = sals_pkg::OUT_W - sals_pkg::LEVEL_W - 5;

	// Configuration registers.
	logic [sals_pkg::PERIOD_W-1:0]  sample_period_q;
	logic [SAMPLE_BITS-1:0]         empty_level_q;
	logic [SAMPLE_BITS-1:0]         full_level_q;
	logic [sals_pkg::TIMEOUT_W-1:0] timeout_ticks_q;

	// Result handoff from the control block.
	logic                           res_valid;
	logic                           res_take;
	logic [sals_pkg::LEVEL_W-1:0]   res_level;
	sals_pkg::flags_t               res_flags;

	// Output register.
	logic                           m_tvalid_q;
	logic [sals_pkg::OUT_W-1:0]     m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= sals_pkg::PERIOD_RESET;
			empty_level_q   <= '0;
			full_level_q    <= sals_pkg::FULL_RESET[SAMPLE_BITS-1:0];
			timeout_ticks_q <= sals_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (sals_pkg::reg_index_t'(cfg_index))
				sals_pkg::REG_PERIOD: begin
					sample_period_q <= cfg_data[sals_pkg::PERIOD_W-1:0];
				end
				sals_pkg::REG_EMPTY: begin
					empty_level_q <= cfg_data[SAMPLE_BITS-1:0];
				end
				sals_pkg::REG_FULL: begin
					full_level_q <= cfg_data[SAMPLE_BITS-1:0];
				end
				sals_pkg::REG_TIMEOUT: begin
					timeout_ticks_q <= cfg_data[sals_pkg::TIMEOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sals_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.action        (s_tuser),
		.sample        (s_tdata[SAMPLE_BITS-1:0]),
		.busy          (s_tdata[SAMPLE_BITS]),
		.lost          (s_tdata[SAMPLE_BITS+1]),
		.setup         (s_tdata[SAMPLE_BITS+2]),
		.started       (s_tdata[SAMPLE_BITS+3]),
		.sample_period (sample_period_q),
		.empty_level   (empty_level_q),
		.full_level    (full_level_q),
		.timeout_ticks (timeout_ticks_q),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res_level     (res_level),
		.res_flags     (res_flags)
	);

	// A finished result moves into the output register when it is empty or
	// being drained in the same cycle.
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {{OUT_PAD{1'b0}},
				res_flags.timed_out, res_flags.stop_conv, res_flags.start_conv,
				res_flags.held, res_flags.updated, res_level};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
